// File: rtl/core/cmbm_pkg.sv
// ----------------------------------------------------------------------------
// cmbm_pkg
// Shared widths, configuration register codes and sequencer types of the
// contact-matrix block mapper.
// ----------------------------------------------------------------------------
package cmbm_pkg;

  localparam int BLOCK_W    = 32;  // result block index
  localparam int BPB_W      = 32;  // bins per block
  localparam int COLS_W     = 16;  // block columns
  localparam int BASE_W     = 17;  // depth base
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MAPPER_MODE    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BINS_PER_BLOCK = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COLUMNS  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_BASE     = 8'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQR,
    ST_SQRT,
    ST_POW_MUL,
    ST_POW_CMP,
    ST_MUL,
    ST_ADD
  } state_t;

  // Which quotient the divider is producing.
  typedef enum logic [1:0] {
    PH_FIRST,
    PH_ROW,
    PH_SPAN
  } phase_t;

endpackage

// File: rtl/core/cmbm_ifs.sv
// ----------------------------------------------------------------------------
// cmbm channel interfaces
// Valid/ready channels for pixels, block indices and configuration writes.
// ----------------------------------------------------------------------------
interface cmbm_pix_if #(parameter int BIN_WIDTH = 32);
  logic                 valid;
  logic                 ready;
  logic [BIN_WIDTH-1:0] row_bin;
  logic [BIN_WIDTH-1:0] col_bin;

  modport source (output valid, output row_bin, output col_bin, input ready);
  modport sink   (input valid, input row_bin, input col_bin, output ready);
endinterface

interface cmbm_res_if;
  import cmbm_pkg::*;
  logic               valid;
  logic               ready;
  logic [BLOCK_W-1:0] block_id;

  modport source (output valid, output block_id, input ready);
  modport sink   (input valid, input block_id, output ready);
endinterface

interface cmbm_cfg_if;
  import cmbm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// File: rtl/core/contact_matrix_block_mapper.sv
// ----------------------------------------------------------------------------
// contact_matrix_block_mapper
// Maps a contact-matrix pixel (two bin indices) to its storage block index.
// ----------------------------------------------------------------------------
// One pixel word is taken at a time; the pixel port is ready only while the
// sequencer is idle, and the finished index waits in an output register so a
// new pixel can start before it is taken. The divisions, the squaring and the
// square root run through one shared add/subtract unit at one bit (or one
// root digit) per cycle; the multiplies use their own multipliers. A
// grid-mode pixel takes two divisions by bins_per_block, a multiply and an
// add; a diagonal-mode pixel takes a half-sum division, squaring of the
// distance, a square root, a division by bins_per_block, then a multiply and
// a compare per depth band k, a multiply and an add.
// Configuration writes are always taken and must only be issued while idle.
module contact_matrix_block_mapper #(
  parameter int BIN_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  cmbm_cfg_if.sink  cfg,
  cmbm_pix_if.sink  pixel,
  cmbm_res_if.source result
);
  import cmbm_pkg::*;

  localparam int W  = BIN_WIDTH;
  localparam int AW = ((2 * W > 34) ? 2 * W : 34) + 1;
  localparam int CW = $clog2(W + 1);
  localparam int PW = W + 1;
  localparam int KW = $clog2(W + 1);

  // Configuration registers.
  logic                mapper_mode;
  logic [BPB_W-1:0]    bins_per_block;
  logic [COLS_W-1:0]   block_columns;
  logic [BASE_W-1:0]   depth_base;

  // Sequencer and datapath registers.
  state_t              state, state_next;
  phase_t              phase;
  logic [CW-1:0]       cnt;
  logic [AW-1:0]       rem;
  logic [W-1:0]        quo;
  logic [2*W-1:0]      sh;
  logic [W-1:0]        diag_gap;
  logic [W-1:0]        rowb;
  logic [BLOCK_W-1:0]  qsave;
  logic [PW-1:0]       rlim;
  logic [PW-1:0]       pw;
  logic [PW+BASE_W-1:0] pprod;
  logic [KW-1:0]       kdep;
  logic [BLOCK_W-1:0]  mprod;
  logic                ovalid;
  logic [BLOCK_W-1:0]  oreg;

  // Shared unit signals.
  logic [AW-1:0]       ux, uy;
  logic                usub;
  logic [AW:0]         usum;
  logic                carry;

  logic [BPB_W-1:0]    bpb_eff;
  logic [BASE_W-1:0]   base_eff;
  logic [W-1:0]        half_sum;
  logic [W-1:0]        abs_diff;
  logic [W-1:0]        quo_next;
  logic [63:0]         quo_next_wide;
  logic [63:0]         quo_wide;
  logic [BLOCK_W-1:0]  mul_a;
  logic [BLOCK_W+COLS_W-1:0] mfull;
  logic [BLOCK_W-1:0]  addend;
  logic                pow_fits;
  logic                out_free;
  logic                pix_take;

  assign bpb_eff  = (bins_per_block == '0) ? BPB_W'(1) : bins_per_block;
  assign base_eff = (depth_base < BASE_W'(2)) ? BASE_W'(2) : depth_base;

  // Floor of the mean without a carry bit beyond W.
  assign half_sum = (pixel.row_bin >> 1) + (pixel.col_bin >> 1)
                  + W'(pixel.row_bin[0] & pixel.col_bin[0]);
  assign abs_diff = (pixel.row_bin > pixel.col_bin) ? pixel.row_bin - pixel.col_bin
                                                    : pixel.col_bin - pixel.row_bin;

  assign usum  = {1'b0, ux} + {1'b0, (usub ? ~uy : uy)} + (AW+1)'(usub);
  assign carry = usum[AW];

  assign quo_next      = {quo[W-2:0], carry};
  assign quo_next_wide = 64'(quo_next);
  assign quo_wide      = 64'(quo);

  assign mul_a  = mapper_mode ? BLOCK_W'(kdep) : qsave;
  assign mfull  = (BLOCK_W+COLS_W)'(mul_a) * (BLOCK_W+COLS_W)'(block_columns);
  assign addend = mapper_mode ? qsave : quo_wide[BLOCK_W-1:0];

  assign pow_fits = (pprod <= (PW+BASE_W)'(rlim));
  assign out_free = !ovalid || result.ready;
  assign pix_take = pixel.valid && (state == ST_IDLE);

  assign pixel.ready     = (state == ST_IDLE);
  assign cfg.ready       = 1'b1;
  assign result.valid    = ovalid;
  assign result.block_id = oreg;

  // Operand selection for the shared add/subtract unit.
  always_comb begin
    ux   = '0;
    uy   = '0;
    usub = 1'b0;
    case (state)
      ST_DIV: begin
        // Restoring division: shift in one dividend bit, try the divisor.
        ux   = {rem[AW-2:0], sh[2*W-1]};
        uy   = AW'(bpb_eff);
        usub = 1'b1;
      end
      ST_SQR: begin
        // Square the distance, multiplier bits taken MSB first.
        ux   = {rem[AW-2:0], 1'b0};
        uy   = sh[2*W-1] ? AW'(diag_gap) : '0;
        usub = 1'b0;
      end
      ST_SQRT: begin
        // Restoring square root: two radicand bits per root bit.
        ux   = {rem[AW-3:0], sh[2*W-1:2*W-2]};
        uy   = AW'({quo, 2'b01});
        usub = 1'b1;
      end
      default: begin
        ux   = '0;
        uy   = '0;
        usub = 1'b0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (pixel.valid) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt == '0) begin
          case (phase)
            PH_FIRST: state_next = mapper_mode ? ST_SQR : ST_DIV;
            PH_ROW:   state_next = ST_MUL;
            PH_SPAN:  state_next = ST_POW_MUL;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_SQR: begin
        if (cnt == '0) begin
          state_next = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (cnt == '0) begin
          state_next = ST_DIV;
        end
      end
      ST_POW_MUL: state_next = ST_POW_CMP;
      ST_POW_CMP: state_next = pow_fits ? ST_POW_MUL : ST_MUL;
      ST_MUL:     state_next = ST_ADD;
      ST_ADD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mapper_mode    <= 1'b1;
      bins_per_block <= BPB_W'(1);
      block_columns  <= COLS_W'(1);
      depth_base     <= BASE_W'(2);
    end else if (cfg.valid) begin
      case (cfg.reg_index)
        CFG_MAPPER_MODE:    mapper_mode    <= cfg.wdata[0];
        CFG_BINS_PER_BLOCK: bins_per_block <= cfg.wdata[BPB_W-1:0];
        CFG_BLOCK_COLUMNS:  block_columns  <= cfg.wdata[COLS_W-1:0];
        CFG_DEPTH_BASE:     depth_base     <= cfg.wdata[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (state == ST_ADD && out_free) begin
      ovalid <= 1'b1;
    end else if (result.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_ADD && out_free) begin
      oreg <= mprod + addend;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (pix_take) begin
          rowb     <= pixel.row_bin;
          diag_gap <= abs_diff;
          rem      <= '0;
          cnt      <= CW'(W - 1);
          phase    <= PH_FIRST;
          sh       <= mapper_mode ? {half_sum, {W{1'b0}}} : {pixel.col_bin, {W{1'b0}}};
        end
      end
      ST_DIV: begin
        rem <= carry ? usum[AW-1:0] : ux;
        quo <= quo_next;
        sh  <= {sh[2*W-2:0], 1'b0};
        cnt <= cnt - CW'(1);
        if (cnt == '0) begin
          case (phase)
            PH_FIRST: begin
              qsave <= quo_next_wide[BLOCK_W-1:0];
              rem   <= '0;
              cnt   <= CW'(W - 1);
              if (mapper_mode) begin
                sh <= {diag_gap, {W{1'b0}}};
              end else begin
                sh    <= {rowb, {W{1'b0}}};
                phase <= PH_ROW;
              end
            end
            PH_SPAN: begin
              // Band limit: B^k must not exceed floor(s / bpb) + 1.
              rlim <= {1'b0, quo_next} + PW'(1);
              pw   <= PW'(1);
              kdep <= '0;
            end
            default: ;
          endcase
        end
      end
      ST_SQR: begin
        rem <= usum[AW-1:0];
        sh  <= {sh[2*W-2:0], 1'b0};
        cnt <= cnt - CW'(1);
        if (cnt == '0) begin
          // Radicand is half the squared distance.
          sh  <= usum[2*W:1];
          rem <= '0;
          quo <= '0;
          cnt <= CW'(W - 1);
        end
      end
      ST_SQRT: begin
        rem <= carry ? usum[AW-1:0] : ux;
        quo <= quo_next;
        sh  <= {sh[2*W-3:0], 2'b00};
        cnt <= cnt - CW'(1);
        if (cnt == '0) begin
          sh    <= {quo_next, {W{1'b0}}};
          rem   <= '0;
          cnt   <= CW'(W - 1);
          phase <= PH_SPAN;
        end
      end
      ST_POW_MUL: begin
        pprod <= (PW+BASE_W)'(pw) * (PW+BASE_W)'(base_eff);
      end
      ST_POW_CMP: begin
        if (pow_fits) begin
          pw   <= pprod[PW-1:0];
          kdep <= kdep + KW'(1);
        end
      end
      ST_MUL: begin
        mprod <= mfull[BLOCK_W-1:0];
      end
      default: ;
    endcase
  end

endmodule
